// ----- sv/sabb_pkg.sv -----
// Shared constants and types for the segment / box overlap pipeline.
// No dependencies; used by sabb_cross and segment_aabb_overlap_test.
package sabb_pkg;

  // Default coordinate width: signed Q8.8
  localparam int COORD_BITS_DEF = 16;

  // Load enables for the pipeline stages inside the cross-axis unit
  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ----- sv/sabb_cross.sv -----
// One cross-product axis test of the segment / box separating axis check.
// Two register stages (products, then difference and bound); depends on sabb_pkg.
module sabb_cross #(
  parameter int COORD_BITS = sabb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  sabb_pkg::stage_en_t          en,
  input  logic signed [COORD_BITS+1:0] ma,
  input  logic signed [COORD_BITS+1:0] mb,
  input  logic signed [COORD_BITS:0]   da,
  input  logic signed [COORD_BITS:0]   db,
  input  logic        [COORD_BITS-2:0] ea,
  input  logic        [COORD_BITS-2:0] eb,
  output logic                         sep
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 3;  // signed m*d product
  localparam int RW = 2 * COORD_BITS;      // unsigned e*|d| product
  localparam int SW = RW + 1;              // bound sum
  localparam int FW = PW + 1;              // product difference
  localparam int XW = FW + 1;              // compare width

  logic        [DW-1:0] da_abs;
  logic        [DW-1:0] db_abs;
  logic signed [PW-1:0] p2_nxt, q2_nxt;
  logic signed [PW-1:0] p2_r, q2_r;
  logic        [RW-1:0] r2a_nxt, r2b_nxt;
  logic        [RW-1:0] r2a_r, r2b_r;
  logic signed [FW-1:0] diff3_nxt, diff3_r;
  logic        [SW-1:0] rhs3_nxt, rhs3_r;
  logic signed [XW-1:0] diff_x, neg_x, rhs_x;

  assign da_abs = da[DW-1] ? DW'(-da) : DW'(da);
  assign db_abs = db[DW-1] ? DW'(-db) : DW'(db);

  assign p2_nxt  = PW'(ma) * PW'(db);
  assign q2_nxt  = PW'(mb) * PW'(da);
  assign r2a_nxt = RW'(ea) * RW'(db_abs);
  assign r2b_nxt = RW'(eb) * RW'(da_abs);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p2_r  <= p2_nxt;
      q2_r  <= q2_nxt;
      r2a_r <= r2a_nxt;
      r2b_r <= r2b_nxt;
    end
  end

  assign diff3_nxt = FW'(p2_r) - FW'(q2_r);
  assign rhs3_nxt  = SW'(r2a_r) + SW'(r2b_r);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      diff3_r <= diff3_nxt;
      rhs3_r  <= rhs3_nxt;
    end
  end

  // |diff| > rhs, checked on both signs to avoid a serial negate and compare
  assign diff_x = XW'(diff3_r);
  assign neg_x  = -diff_x;
  assign rhs_x  = $signed({{(XW - SW){1'b0}}, rhs3_r});
  assign sep    = (diff_x > rhs_x) || (neg_x > rhs_x);

endmodule

// ----- sv/segment_aabb_overlap_test.sv -----
// Segment versus axis-aligned box overlap test, top level.
// Depends on sabb_pkg and sabb_cross.
//
// Usage:
//   Input channel in_*: one item per handshake, a segment (start, end) and a
//   box (centre, full size) in signed Q8.8 at the default COORD_BITS.
//   in_tdata from bit 0 up: start_x, start_y, start_z, end_x, end_y, end_z,
//   box_center_x, box_center_y, box_center_z (COORD_BITS each), then
//   box_size_x, box_size_y, box_size_z (COORD_BITS-1 each), zero padding.
//   Result channel out_*: one item per input item, in order; out_tdata[0]
//   is overlap (1 when the segment touches the box), the rest zero.
// Order: an accepted item is registered in stages 1 to 4 in turn, and
//   out_tvalid is high while stage 4 holds it.
// Throughput: one item per cycle unless stalled; four register stages (midpoint and
//   half-vector, products, difference and bound, result) each hold one item.
// Stall: each stage holds while the next one is full and held; bubbles
//   close up, so in_tready stays high as long as any stage is free.
// Reset: rst_n low clears all stage valid bits; the pipe is empty afterwards.
module segment_aabb_overlap_test #(
  parameter int COORD_BITS = sabb_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, box_center_x/_y/_z,
  // box_size_x/_y/_z, zero padding
  input  logic [((12*COORD_BITS-3+7)/8)*8-1:0]         in_tdata,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [7:0]                                   out_tdata  // overlap, zero padding
);

  localparam int C  = COORD_BITS;
  localparam int MW = C + 2;   // doubled midpoint offset
  localparam int DW = C + 1;   // doubled half-vector
  localparam int EW = C - 1;   // doubled half-extent
  localparam int OFS_END  = 3 * C;
  localparam int OFS_CTR  = 6 * C;
  localparam int OFS_SIZE = 9 * C;

  logic en1, en2, en3, en4;
  logic v1_r, v2_r, v3_r, v4_r;
  sabb_pkg::stage_en_t cen;

  logic signed [C-1:0]  s_f [3];
  logic signed [C-1:0]  t_f [3];
  logic signed [C-1:0]  c_f [3];
  logic        [EW-1:0] e_f [3];

  logic signed [MW-1:0] m1_nxt [3];
  logic signed [DW-1:0] d1_nxt [3];
  logic signed [MW-1:0] m1_r [3];
  logic signed [DW-1:0] d1_r [3];
  logic        [EW-1:0] e1_r [3];

  logic        [MW-1:0] m_abs [3];
  logic        [DW-1:0] d_abs [3];
  logic        [2:0]    axis_hit;
  logic                 axis_sep2_nxt, axis_sep2_r, axis_sep3_r;
  logic        [2:0]    cross_sep;
  logic                 overlap_nxt, overlap_r;

  // Stage enables: a stage loads when empty or when its item moves on
  assign en4       = !v4_r || out_tready;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign cen.s2    = en2;
  assign cen.s3    = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: 2m = s + t - 2c, 2d = t - s, 2e = size
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_f[k]    = in_tdata[k*C +: C];
      t_f[k]    = in_tdata[OFS_END + k*C +: C];
      c_f[k]    = in_tdata[OFS_CTR + k*C +: C];
      e_f[k]    = in_tdata[OFS_SIZE + k*EW +: EW];
      m1_nxt[k] = MW'(s_f[k]) + MW'(t_f[k]) - (MW'(c_f[k]) <<< 1);
      d1_nxt[k] = DW'(t_f[k]) - DW'(s_f[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        m1_r[k] <= m1_nxt[k];
        d1_r[k] <= d1_nxt[k];
        e1_r[k] <= e_f[k];
      end
    end
  end

  // Stage 2: coordinate axes, |m| > e + |d|
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_abs[k]    = m1_r[k][MW-1] ? MW'(-m1_r[k]) : MW'(m1_r[k]);
      d_abs[k]    = d1_r[k][DW-1] ? DW'(-d1_r[k]) : DW'(d1_r[k]);
      axis_hit[k] = m_abs[k] > (MW'(e1_r[k]) + MW'(d_abs[k]));
    end
  end
  assign axis_sep2_nxt = |axis_hit;

  always_ff @(posedge clk) begin
    if (en2) axis_sep2_r <= axis_sep2_nxt;
    if (en3) axis_sep3_r <= axis_sep2_r;
  end

  // Cross-product axes: d x X, d x Y, d x Z
  sabb_cross #(.COORD_BITS(COORD_BITS)) u_cross_x (
    .clk (clk), .en (cen),
    .ma (m1_r[1]), .mb (m1_r[2]), .da (d1_r[1]), .db (d1_r[2]),
    .ea (e1_r[1]), .eb (e1_r[2]), .sep (cross_sep[0])
  );

  sabb_cross #(.COORD_BITS(COORD_BITS)) u_cross_y (
    .clk (clk), .en (cen),
    .ma (m1_r[2]), .mb (m1_r[0]), .da (d1_r[2]), .db (d1_r[0]),
    .ea (e1_r[2]), .eb (e1_r[0]), .sep (cross_sep[1])
  );

  sabb_cross #(.COORD_BITS(COORD_BITS)) u_cross_z (
    .clk (clk), .en (cen),
    .ma (m1_r[0]), .mb (m1_r[1]), .da (d1_r[0]), .db (d1_r[1]),
    .ea (e1_r[0]), .eb (e1_r[1]), .sep (cross_sep[2])
  );

  // Stage 4: overlap only when no axis separates
  assign overlap_nxt = !(axis_sep3_r || (|cross_sep));

  always_ff @(posedge clk) begin
    if (en4) overlap_r <= overlap_nxt;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {7'b0, overlap_r};

`ifndef NO_ASSERTIONS
  // A free output side must never hold off the input
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while the output side is free");

  // With the output side free after the handshake, an accepted item reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("item did not reach the output in four cycles");

  // A held result keeps its stage full
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_tready) |=> (v4_r && $stable(overlap_r)))
    else $error("held result lost or changed");
`endif

endmodule
